FILE: rtl/split_gain_evaluator_assert.svh
// ---------------------------------------------------------------------------
// Split gain evaluator assertion macros
// Property wrappers for the split gain evaluator; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef SPLIT_GAIN_EVALUATOR_ASSERT_SVH
`define SPLIT_GAIN_EVALUATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SGE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("split gain evaluator: assertion failed");

// next-cycle implication
`define SGE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("split gain evaluator: assertion failed");

`else

`define SGE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SGE_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/sge_pkg.sv
// ---------------------------------------------------------------------------
// Split gain evaluator package
// Fixed-point widths, payload types and register indexes.
// ---------------------------------------------------------------------------
package sge_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_SAMPLES = 4096;
  localparam int CNT_W       = 13;
  localparam int SUM_W       = 48;
  localparam int VAL_W       = 32;
  localparam int GAIN_W      = 64;
  localparam int LAMBDA_W    = 24;
  // denominator: tally in Q.16 plus lambda
  localparam int DEN_W       = CNT_W + FRAC_BITS + 1;
  // square of the sum magnitude
  localparam int SQ_W        = 2 * SUM_W;
  localparam int DIV_STEPS   = SQ_W;
  localparam int DCNT_W      = $clog2(DIV_STEPS);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic signed [GAIN_W-1:0] USELESS_GAIN = -(64'sd1 <<< FRAC_BITS);
  localparam logic [CNT_W-1:0] TALLY_MAX = CNT_W'(MAX_SAMPLES);

  // register indexes (word address)
  localparam logic [1:0] REG_SPLIT_VALUE = 2'd0;
  localparam logic [1:0] REG_CAT_MODE    = 2'd1;
  localparam logic [1:0] REG_LAMBDA      = 2'd2;

  typedef struct packed {
    logic signed [VAL_W-1:0] sample_value;
    logic signed [VAL_W-1:0] gradient;
    logic                    is_live;
    logic                    last_sample;
  } sample_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain;
    logic                     useless;
    logic [CNT_W-1:0]         left_count;
    logic [CNT_W-1:0]         right_count;
  } result_t;

endpackage

FILE: rtl/sge_stream_if.sv
// ---------------------------------------------------------------------------
// Split gain evaluator stream interface
// Valid/ready channel carrying one payload per transfer.
// ---------------------------------------------------------------------------
interface sge_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/split_gain_evaluator.sv
// Samples are taken one per cycle while the evaluator accumulates. After a last
// sample the input is not ready until its result is registered, which waits for
// room on the result channel. One shared 32x32 multiplier squares each side's
// gradient sum, then a radix-2 restoring divider divides it by the denominator.
// Reset (async, active low) clears config, control, result and accumulator state.
// ---------------------------------------------------------------------------
// Split gain evaluator
// Routes live samples left or right of a split value, keeps gradient sums and
// counts per side, and on the last sample of a run produces the L2 split gain.
// ---------------------------------------------------------------------------
`include "split_gain_evaluator_assert.svh"

module split_gain_evaluator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  sge_stream_if.sink   samples_i,
  sge_stream_if.source result_o
);

  localparam int HI_W = sge_pkg::SUM_W - 32;

  typedef enum logic [2:0] {
    S_ACC,
    S_CHK,
    S_PREP,
    S_MUL,
    S_DIV,
    S_FIN
  } state_e;

  // configuration registers
  logic signed [31:0]                split_value_q;
  logic                              cat_mode_q;
  logic [sge_pkg::LAMBDA_W-1:0]      lambda_q;

  // control and accumulators
  state_e                            state_q;
  logic                              side_q;
  logic [1:0]                        mstep_q;
  logic [sge_pkg::DCNT_W-1:0]        dcnt_q;
  logic signed [sge_pkg::SUM_W-1:0]  left_sum_q, right_sum_q;
  logic [sge_pkg::CNT_W-1:0]         left_tally_q, right_tally_q;
  logic                              out_valid_q;
  sge_pkg::result_t                  out_q;

  // datapath
  logic [sge_pkg::SUM_W-1:0]         mag_q;
  logic [sge_pkg::DEN_W-1:0]         den_q;
  logic [sge_pkg::SQ_W-1:0]          acc_q;
  logic [63:0]                       prod_q;
  logic [sge_pkg::DEN_W-1:0]         rem_q;
  logic [63:0]                       quo_q;
  logic                              ovf_q;
  logic [sge_pkg::GAIN_W-1:0]        term_l_q, term_r_q;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_value_q <= '0;
      cat_mode_q    <= 1'b0;
      lambda_q      <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        sge_pkg::REG_SPLIT_VALUE: split_value_q <= pwdata;
        sge_pkg::REG_CAT_MODE:    cat_mode_q    <= pwdata[0];
        sge_pkg::REG_LAMBDA:      lambda_q      <= pwdata[sge_pkg::LAMBDA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      sge_pkg::REG_SPLIT_VALUE: prdata = split_value_q;
      sge_pkg::REG_CAT_MODE:    prdata = {31'b0, cat_mode_q};
      sge_pkg::REG_LAMBDA:      prdata = {{(32-sge_pkg::LAMBDA_W){1'b0}}, lambda_q};
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sample routing and saturating accumulation
  // ---------------------------------------------------------------------------
  function automatic logic signed [sge_pkg::SUM_W-1:0] sat_add(
    input logic signed [sge_pkg::SUM_W-1:0] s,
    input logic signed [sge_pkg::VAL_W-1:0] g
  );
    logic signed [sge_pkg::SUM_W:0] r;
    r = {s[sge_pkg::SUM_W-1], s} +
        {{(sge_pkg::SUM_W+1-sge_pkg::VAL_W){g[sge_pkg::VAL_W-1]}}, g};
    if (r[sge_pkg::SUM_W] != r[sge_pkg::SUM_W-1]) begin
      return r[sge_pkg::SUM_W] ? sge_pkg::SUM_MIN : sge_pkg::SUM_MAX;
    end
    return r[sge_pkg::SUM_W-1:0];
  endfunction

  sge_pkg::sample_t smp;
  logic in_xfer, go_left, useless_c;
  assign smp       = samples_i.payload;
  assign samples_i.ready = (state_q == S_ACC);
  assign in_xfer   = samples_i.valid && samples_i.ready;
  assign go_left   = cat_mode_q ? (smp.sample_value == split_value_q)
                                : (smp.sample_value < split_value_q);
  assign useless_c = (left_tally_q == '0) || (right_tally_q == '0);

  // ---------------------------------------------------------------------------
  // Shared arithmetic: square by partial products, then restoring division
  // ---------------------------------------------------------------------------
  logic signed [sge_pkg::SUM_W-1:0] side_sum;
  logic [sge_pkg::CNT_W-1:0]        side_tally;
  logic [sge_pkg::SUM_W-1:0]        mag_c;
  logic [sge_pkg::DEN_W-1:0]        den_c;
  logic [31:0]                      op_a, op_b;
  logic [HI_W-1:0]                  mag_hi;
  logic [31:0]                      mag_lo;
  logic [sge_pkg::SQ_W-1:0]         addend;

  assign side_sum   = side_q ? right_sum_q : left_sum_q;
  assign side_tally = side_q ? right_tally_q : left_tally_q;
  assign mag_c      = side_sum[sge_pkg::SUM_W-1] ? (~side_sum + 1'b1) : side_sum;
  assign den_c      = sge_pkg::DEN_W'({side_tally, {sge_pkg::FRAC_BITS{1'b0}}}) +
                      sge_pkg::DEN_W'(lambda_q);
  assign mag_hi     = mag_q[sge_pkg::SUM_W-1:32];
  assign mag_lo     = mag_q[31:0];

  // operand pair per step: lo*lo, hi*lo (counted twice), hi*hi
  always_comb begin
    case (mstep_q)
      2'd0: begin
        op_a = mag_lo;
        op_b = mag_lo;
      end
      2'd1: begin
        op_a = {{(32-HI_W){1'b0}}, mag_hi};
        op_b = mag_lo;
      end
      2'd2: begin
        op_a = {{(32-HI_W){1'b0}}, mag_hi};
        op_b = {{(32-HI_W){1'b0}}, mag_hi};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // product registered last step, aligned to its weight
  always_comb begin
    case (mstep_q)
      2'd1:    addend = sge_pkg::SQ_W'(prod_q);
      2'd2:    addend = sge_pkg::SQ_W'({prod_q, 33'b0});
      2'd3:    addend = sge_pkg::SQ_W'({prod_q, 64'b0});
      default: addend = '0;
    endcase
  end

  // one divider step: shift in the next dividend bit, subtract when it fits
  logic [sge_pkg::DEN_W:0]       rem_sh, rem_sub;
  logic                          geq;
  logic [sge_pkg::DEN_W-1:0]     rem_d;
  logic [63:0]                   quo_d;
  logic                          ovf_d;
  logic [sge_pkg::GAIN_W-1:0]    term_c;
  logic [sge_pkg::GAIN_W-1:0]    gsum, gain_c;

  assign rem_sh  = {rem_q, acc_q[sge_pkg::SQ_W-1]};
  assign geq     = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign rem_d   = geq ? rem_sub[sge_pkg::DEN_W-1:0] : rem_sh[sge_pkg::DEN_W-1:0];
  assign quo_d   = {quo_q[62:0], geq};
  assign ovf_d   = ovf_q | quo_q[63];
  assign term_c  = (ovf_d || quo_d[63]) ? sge_pkg::GAIN_MAX : quo_d;

  // both terms stay below 2^63, so the sum cannot wrap
  assign gsum    = term_l_q + term_r_q;
  assign gain_c  = gsum[sge_pkg::GAIN_W-1] ? sge_pkg::GAIN_MAX : gsum;

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_PREP: begin
        mag_q <= mag_c;
        den_q <= den_c;
        acc_q <= '0;
      end
      S_MUL: begin
        prod_q <= op_a * op_b;
        acc_q  <= acc_q + addend;
        if (mstep_q == 2'd3) begin
          rem_q <= '0;
          quo_q <= '0;
          ovf_q <= 1'b0;
        end
      end
      S_DIV: begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        ovf_q <= ovf_d;
        acc_q <= {acc_q[sge_pkg::SQ_W-2:0], 1'b0};
        if (dcnt_q == sge_pkg::DCNT_W'(sge_pkg::DIV_STEPS - 1)) begin
          if (side_q) begin
            term_r_q <= term_c;
          end else begin
            term_l_q <= term_c;
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer, accumulators and result register
  // ---------------------------------------------------------------------------
  logic out_free;
  assign out_free = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_ACC;
      side_q        <= 1'b0;
      mstep_q       <= '0;
      dcnt_q        <= '0;
      left_sum_q    <= '0;
      right_sum_q   <= '0;
      left_tally_q  <= '0;
      right_tally_q <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      // in S_FIN a leaving result is replaced by the new one below
      if (out_valid_q && result_o.ready && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_ACC: begin
          if (in_xfer) begin
            if (smp.is_live) begin
              if (go_left) begin
                left_sum_q <= sat_add(left_sum_q, smp.gradient);
                if (left_tally_q < sge_pkg::TALLY_MAX) begin
                  left_tally_q <= left_tally_q + 1'b1;
                end
              end else begin
                right_sum_q <= sat_add(right_sum_q, smp.gradient);
                if (right_tally_q < sge_pkg::TALLY_MAX) begin
                  right_tally_q <= right_tally_q + 1'b1;
                end
              end
            end
            if (smp.last_sample) begin
              state_q <= S_CHK;
            end
          end
        end
        S_CHK: begin
          side_q <= 1'b0;
          state_q <= useless_c ? S_FIN : S_PREP;
        end
        S_PREP: begin
          mstep_q <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          mstep_q <= mstep_q + 1'b1;
          if (mstep_q == 2'd3) begin
            dcnt_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == sge_pkg::DCNT_W'(sge_pkg::DIV_STEPS - 1)) begin
            if (side_q) begin
              state_q <= S_FIN;
            end else begin
              side_q  <= 1'b1;
              state_q <= S_PREP;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_q.gain        <= useless_c ? sge_pkg::USELESS_GAIN : gain_c;
            out_q.useless     <= useless_c;
            out_q.left_count  <= left_tally_q;
            out_q.right_count <= right_tally_q;
            out_valid_q       <= 1'b1;
            left_sum_q        <= '0;
            right_sum_q       <= '0;
            left_tally_q      <= '0;
            right_tally_q     <= '0;
            state_q           <= S_ACC;
          end
        end
        default: state_q <= S_ACC;
      endcase
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SGE_ASSERT_IMP(a_useless_gain, clk_i, rst_ni, out_valid_q && out_q.useless, out_q.gain == sge_pkg::USELESS_GAIN)
  `SGE_ASSERT_IMP(a_useful_counts, clk_i, rst_ni, out_valid_q && !out_q.useless, (out_q.left_count != '0) && (out_q.right_count != '0))
  `SGE_ASSERT_IMP(a_gain_nonneg, clk_i, rst_ni, out_valid_q && !out_q.useless, !out_q.gain[sge_pkg::GAIN_W-1])
  `SGE_ASSERT_NXT(a_busy_after_last, clk_i, rst_ni, in_xfer && smp.last_sample, !samples_i.ready)

endmodule

FILE: verif/split_gain_checker.sv
// ---------------------------------------------------------------------------
// Split gain checker
// Watches the register port and both stream channels of the split gain
// evaluator. Keeps its own copy of the registers and per-side accumulators,
// predicts the gain of every run and compares each result transfer with the
// oldest outstanding prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module split_gain_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              sample_valid_i,
  input  logic              sample_ready_i,
  input  sge_pkg::sample_t  sample_i,
  input  logic              result_valid_i,
  input  logic              result_ready_i,
  input  sge_pkg::result_t  result_i,
  output int                mismatch_count_o,
  output int                gains_pending_o,
  output int                samples_seen_o,
  output int                results_seen_o,
  output int                useless_seen_o,
  output int                saturated_seen_o
);

  // register copies
  logic signed [sge_pkg::VAL_W-1:0] split_q;
  logic                             cat_q;
  logic [sge_pkg::LAMBDA_W-1:0]     lambda_q;

  // per-side accumulators of the run in progress
  logic signed [sge_pkg::SUM_W-1:0] left_sum_q;
  logic signed [sge_pkg::SUM_W-1:0] right_sum_q;
  logic [sge_pkg::CNT_W-1:0]        left_n_q;
  logic [sge_pkg::CNT_W-1:0]        right_n_q;

  // predicted results, oldest first
  sge_pkg::result_t pending_gains[$];

  // gradient sum with saturation at the 48-bit signed range
  function automatic logic signed [sge_pkg::SUM_W-1:0] grad_sum_add(
    input logic signed [sge_pkg::SUM_W-1:0] acc,
    input logic signed [sge_pkg::VAL_W-1:0] grad
  );
    logic signed [63:0] r;
    r = acc + grad;
    if (r > sge_pkg::SUM_MAX) return sge_pkg::SUM_MAX;
    if (r < sge_pkg::SUM_MIN) return sge_pkg::SUM_MIN;
    return r[sge_pkg::SUM_W-1:0];
  endfunction

  // floor(sum^2 / (n*2^16 + lambda)), saturated; zero for a zero divisor
  function automatic logic [sge_pkg::GAIN_W-1:0] gain_term(
    input logic signed [sge_pkg::SUM_W-1:0] sum,
    input logic [sge_pkg::CNT_W-1:0]        n,
    input logic [sge_pkg::LAMBDA_W-1:0]     lam
  );
    logic [sge_pkg::SUM_W-1:0] mag;
    logic [127:0]              sq;
    logic [127:0]              den;
    logic [127:0]              quo;
    mag = (sum < 0) ? -sum : sum;
    sq  = 128'(mag) * 128'(mag);
    den = (128'(n) << sge_pkg::FRAC_BITS) + 128'(lam);
    if (den == 0) return '0;
    quo = sq / den;
    if (quo > 128'(sge_pkg::GAIN_MAX)) return sge_pkg::GAIN_MAX;
    return quo[sge_pkg::GAIN_W-1:0];
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count_o < 100) begin
      $display("%0t: result %0d: %s got 0x%0h, expected 0x%0h",
               $time, results_seen_o, field, got, want);
    end
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    sge_pkg::result_t         want;
    logic                     go_left;
    logic [sge_pkg::GAIN_W:0] total;
    if (!rst_ni) begin
      split_q     = '0;
      cat_q       = 1'b0;
      lambda_q    = '0;
      left_sum_q  = '0;
      right_sum_q = '0;
      left_n_q    = '0;
      right_n_q   = '0;
      pending_gains.delete();
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          sge_pkg::REG_SPLIT_VALUE: split_q  = pwdata;
          sge_pkg::REG_CAT_MODE:    cat_q    = pwdata[0];
          sge_pkg::REG_LAMBDA:      lambda_q = pwdata[sge_pkg::LAMBDA_W-1:0];
          default: ;
        endcase
      end

      // sample transfer: route, accumulate, predict on the last one
      if (sample_valid_i && sample_ready_i) begin
        samples_seen_o++;
        if (sample_i.is_live) begin
          go_left = cat_q ? ($signed(sample_i.sample_value) == split_q)
                          : ($signed(sample_i.sample_value) < split_q);
          if (go_left) begin
            left_sum_q = grad_sum_add(left_sum_q, $signed(sample_i.gradient));
            if (left_n_q < sge_pkg::TALLY_MAX) left_n_q++;
          end else begin
            right_sum_q = grad_sum_add(right_sum_q, $signed(sample_i.gradient));
            if (right_n_q < sge_pkg::TALLY_MAX) right_n_q++;
          end
        end
        if (sample_i.last_sample) begin
          want.left_count  = left_n_q;
          want.right_count = right_n_q;
          want.useless     = (left_n_q == 0) || (right_n_q == 0);
          if (want.useless) begin
            want.gain = sge_pkg::USELESS_GAIN;
          end else begin
            total = {1'b0, gain_term(left_sum_q, left_n_q, lambda_q)}
                  + {1'b0, gain_term(right_sum_q, right_n_q, lambda_q)};
            want.gain = (total > {1'b0, sge_pkg::GAIN_MAX}) ? sge_pkg::GAIN_MAX
                                                            : total[sge_pkg::GAIN_W-1:0];
          end
          pending_gains.insert(pending_gains.size(), want);
          left_sum_q  = '0;
          right_sum_q = '0;
          left_n_q    = '0;
          right_n_q   = '0;
        end
      end

      // result transfer: compare with the oldest prediction
      if (result_valid_i && result_ready_i) begin
        results_seen_o++;
        if (pending_gains.size() == 0) begin
          report_mismatch("unexpected result, gain", result_i.gain, '0);
        end else begin
          want = pending_gains.pop_front();
          if (want.useless) useless_seen_o++;
          if (want.gain == sge_pkg::GAIN_MAX) saturated_seen_o++;
          if (result_i.gain !== want.gain)
            report_mismatch("gain", result_i.gain, want.gain);
          if (result_i.useless !== want.useless)
            report_mismatch("useless", 64'(result_i.useless), 64'(want.useless));
          if (result_i.left_count !== want.left_count)
            report_mismatch("left_count", 64'(result_i.left_count), 64'(want.left_count));
          if (result_i.right_count !== want.right_count)
            report_mismatch("right_count", 64'(result_i.right_count),
                            64'(want.right_count));
        end
      end
    end
    gains_pending_o = pending_gains.size();
  end

endmodule

FILE: verif/tb_split_gain_evaluator.sv
// ---------------------------------------------------------------------------
// Split gain evaluator testbench
// Drives runs of samples and register settings into the evaluator, with
// random gaps and stalls on both channels, and leaves prediction and
// comparison to the checker. Covers a directed set of corner runs, one
// longer run of alternating extreme gradients, and random runs under
// extreme and random register settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_split_gain_evaluator;

  localparam int ITEM_TARGET  = 1200;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int LONG_PAIRS   = 40;
  localparam int HOLD_CYCLES  = 900;
  localparam int DRAIN_CYCLES = 250;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sge_stream_if #(.payload_t(sge_pkg::sample_t)) smp_if ();
  sge_stream_if #(.payload_t(sge_pkg::result_t)) res_if ();

  int  cycle_count;
  int  random_items;
  int  phase_count;
  bit  tx_gaps;
  bit  rx_gaps;
  int  hold_asked;
  int  hold_done;
  int  stall_left;
  logic signed [31:0] cur_split;

  int mismatches;
  int pending;
  int samples_seen;
  int results_seen;
  int useless_seen;
  int saturated_seen;

  split_gain_evaluator u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .samples_i (smp_if),
    .result_o  (res_if)
  );

  split_gain_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .sample_valid_i   (smp_if.valid),
    .sample_ready_i   (smp_if.ready),
    .sample_i         (smp_if.payload),
    .result_valid_i   (res_if.valid),
    .result_ready_i   (res_if.ready),
    .result_i         (res_if.payload),
    .mismatch_count_o (mismatches),
    .gains_pending_o  (pending),
    .samples_seen_o   (samples_seen),
    .results_seen_o   (results_seen),
    .useless_seen_o   (useless_seen),
    .saturated_seen_o (saturated_seen)
  );

  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic sge_pkg::sample_t make_sample(input logic [31:0] v,
                                                   input logic [31:0] g,
                                                   input logic live, input logic last);
    sge_pkg::sample_t s;
    s.sample_value = v;
    s.gradient     = g;
    s.is_live      = live;
    s.last_sample  = last;
    return s;
  endfunction

  // feature values cluster around the split so both sides and ties occur
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return cur_split + 32'($urandom_range(0, 8)) - 32'd4;
    if (r < 55) return cur_split;
    if (r < 60) return 32'h8000_0000;
    if (r < 65) return 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_grad();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom;
    if (r < 80) return 32'($urandom_range(0, 2048)) - 32'd1024;
    if (r < 85) return 32'h8000_0000;
    if (r < 90) return 32'h7FFF_FFFF;
    return 32'd0;
  endfunction

  // one sample transfer, optionally preceded by an idle gap
  task automatic send_sample(input sge_pkg::sample_t s);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      smp_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    smp_if.valid   <= 1'b1;
    smp_if.payload <= s;
    do begin
      @(posedge clk_i);
    end while (!smp_if.ready);
  endtask

  // stop offering samples and wait until every predicted gain has come back
  task automatic settle(input int extra);
    @(negedge clk_i);
    smp_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] split, input logic cat,
                            input logic [23:0] lam);
    write_reg(sge_pkg::REG_SPLIT_VALUE, split);
    write_reg(sge_pkg::REG_CAT_MODE, {31'd0, cat});
    write_reg(sge_pkg::REG_LAMBDA, {8'd0, lam});
    cur_split = split;
    phase_count++;
  endtask

  // one run of random length and content
  task automatic random_run();
    int r;
    int len;
    int i;
    r   = $urandom_range(0, 99);
    len = (r < 80) ? $urandom_range(1, 8) : (r < 97) ? $urandom_range(9, 30)
                                                     : $urandom_range(31, 120);
    for (i = 0; i < len; i++) begin
      send_sample(make_sample(pick_value(), pick_grad(),
                              $urandom_range(0, 99) < 85, i == len - 1));
      random_items++;
    end
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    stall_left   = 0;
    hold_done    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_asked != hold_done) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_done++;
      end else if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (rx_gaps) stall_left = pick_gap();
      end
    end
  end

  // stimulus
  initial begin
    int p;
    int n;
    int k;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    smp_if.valid   = 1'b0;
    smp_if.payload = '0;
    cycle_count    = 0;
    random_items   = 0;
    phase_count    = 0;
    hold_asked     = 0;
    tx_gaps        = 1'b0;
    rx_gaps        = 1'b0;
    cur_split      = '0;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // reset settings: numeric split at zero, no regularization
    // both sides populated, field extremes, one dead sample in between
    send_sample(make_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0));
    send_sample(make_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0));
    send_sample(make_sample(32'h0000_0000, 32'h0000_1234, 1'b0, 1'b0));
    send_sample(make_sample(32'hFFFF_0000, 32'h0001_0000, 1'b1, 1'b1));
    // only the right side
    send_sample(make_sample(32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1));
    // dead last sample only: both sides empty
    send_sample(make_sample(32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1));
    // only the left side
    send_sample(make_sample(32'hFFFF_FFFF, 32'h0001_0000, 1'b1, 1'b1));
    settle(8);

    // categorical match with maximum lambda
    set_config(32'h0003_0000, 1'b1, 24'hFF_FFFF);
    send_sample(make_sample(32'h0003_0000, 32'h7FFF_FFFF, 1'b1, 1'b0));
    send_sample(make_sample(32'h0003_0001, 32'h0000_0200, 1'b1, 1'b0));
    send_sample(make_sample(32'h0002_FFFF, 32'hFFFF_FE00, 1'b1, 1'b0));
    send_sample(make_sample(32'h0003_0000, 32'h8000_0000, 1'b1, 1'b1));
    send_sample(make_sample(32'h0003_0000, 32'h0000_0005, 1'b1, 1'b1));
    settle(8);

    // longer run: extreme gradients pile up on both sides
    set_config(32'h0000_0000, 1'b0, 24'hFF_FFFF);
    for (k = 0; k < LONG_PAIRS; k++) begin
      send_sample(make_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0));
      send_sample(make_sample(32'h0000_0000, 32'h8000_0000, 1'b1, 1'b0));
    end
    send_sample(make_sample(32'h0000_0001, 32'h0000_0000, 1'b0, 1'b1));
    settle(8);

    // random phases, the first few at register extremes
    p = 0;
    while ((random_items < ITEM_TARGET) || (p <= 5)) begin
      case (p)
        0: set_config(32'h8000_0000, 1'b0, 24'h00_0000);
        1: set_config(32'h7FFF_FFFF, 1'b0, 24'hFF_FFFF);
        2: set_config(32'h8000_0000, 1'b1, 24'hFF_FFFF);
        3: set_config(32'h7FFF_FFFF, 1'b1, 24'h00_0000);
        default: begin
          n = $urandom_range(0, 99);
          set_config(($urandom_range(0, 1) != 0) ? $urandom
                                                 : 32'($urandom_range(0, 8191)) - 32'd4096,
                     1'($urandom_range(0, 1)),
                     (n < 30) ? 24'h00_0000 : (n < 50) ? 24'hFF_FFFF : 24'($urandom));
        end
      endcase
      tx_gaps = (p % 3) != 0;
      rx_gaps = (p % 3) == 1;
      if (p == 5) begin
        // result side holds off while samples keep coming
        tx_gaps = 1'b0;
        hold_asked++;
      end
      n = $urandom_range(4, 10);
      for (k = 0; k < n; k++) random_run();
      settle(8);
      p++;
    end

    settle(DRAIN_CYCLES);
    $display("Ran %0d sample transfers giving %0d gain results", samples_seen, results_seen);
    $display("(%0d one-sided, %0d saturated) over %0d register settings",
             useless_seen, saturated_seen, phase_count);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sge_pkg.sv
rtl/sge_stream_if.sv
rtl/split_gain_evaluator.sv
verif/split_gain_checker.sv
verif/tb_split_gain_evaluator.sv
